// ----- rtl/core/cagc_pkg.sv -----
// ----------------------------------------------------------------------------
// cagc_pkg
// shared widths, reset values and register indexes of the clip driven agc
// ----------------------------------------------------------------------------
`default_nettype none

package cagc_pkg;

  // field widths
  localparam int unsigned SampleW  = 32;
  localparam int unsigned ThrW     = 31;
  localparam int unsigned TimeW    = 22;
  localparam int unsigned DownW    = 16;
  localparam int unsigned GainW    = 17;
  localparam int unsigned PctW     = 7;
  localparam int unsigned FracW    = 16;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;

  // shared multiplier
  localparam int unsigned MulW  = 17;
  localparam int unsigned ProdW = 2 * MulW;

  localparam int unsigned MaxBlockDef = 1024;

  // register reset values
  localparam logic [ThrW-1:0]  ClipThrRst  = 31'd1932735232;
  localparam logic [TimeW-1:0] StepDnRst   = 22'd144000;
  localparam logic [TimeW-1:0] StepUpRst   = 22'd1440000;
  localparam logic [DownW-1:0] DownRatRst  = 16'd46399;
  localparam logic [GainW-1:0] UpRatRst    = 17'd73531;
  localparam logic [GainW-1:0] FloorRst    = 17'd3277;
  localparam logic [GainW-1:0] CeilRst     = 17'd65536;
  localparam logic [GainW-1:0] StartGnRst  = 17'd65536;

  localparam logic [TimeW-1:0] TimeMax = {TimeW{1'b1}};
  localparam logic [MulW-1:0]  Hundred = 17'd100;
  localparam logic [PctW-1:0]  PctMax  = 7'd100;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_CLIP_THR   = 3'd0,
    CFG_STEP_DN    = 3'd1,
    CFG_STEP_UP    = 3'd2,
    CFG_DOWN_RATIO = 3'd3,
    CFG_UP_RATIO   = 3'd4,
    CFG_GAIN_FLOOR = 3'd5,
    CFG_GAIN_CEIL  = 3'd6,
    CFG_START_GAIN = 3'd7
  } cfg_idx_e;

endpackage

`default_nettype wire

// ----- rtl/core/cagc_if.sv -----
// ----------------------------------------------------------------------------
// cagc_if
// valid/ready channels of the clip driven agc: samples, results, config
// ----------------------------------------------------------------------------
`default_nettype none

interface cagc_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [cagc_pkg::SampleW-1:0] sample;
  logic                                last;

  modport source (output valid, output sample, output last, input ready);
  modport sink   (input valid, input sample, input last, output ready);
endinterface

interface cagc_out_if;
  logic                            valid;
  logic                            ready;
  logic [cagc_pkg::GainW-1:0]      gain;
  logic [cagc_pkg::PctW-1:0]       rf_gain_percent;
  logic                            changed;
  logic                            overloaded;

  modport source (output valid, output gain, output rf_gain_percent,
                  output changed, output overloaded, input ready);
  modport sink   (input valid, input gain, input rf_gain_percent,
                  input changed, input overloaded, output ready);
endinterface

interface cagc_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [cagc_pkg::CfgIdxW-1:0]  index;
  logic [cagc_pkg::CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/clip_driven_step_agc_top.sv -----
// ----------------------------------------------------------------------------
// clip_driven_step_agc_top
// step agc driven by per-block clip counts, one shared multiplier
// ----------------------------------------------------------------------------
//
//  channel | dir | payload                                        | transaction
//  --------+-----+------------------------------------------------+---------------------
//  cfg_i   | in  | index (3b), data (32b)                         | valid & ready
//  in_i    | in  | sample (32b signed), last (1b)                 | valid & ready
//  out_o   | out | gain (17b), rf_gain_percent (7b), changed,     | valid & ready
//          |     | overloaded                                     |
//
//  a sample inside a block is counted and compared, ready stays high
//  a block end runs clipmul, eval, gainmul and clamp on a step only, pctmul and
//  out: the multiplier is used in turn for clip*100, gain*ratio and gain*100,
//  each product registered before use
//  the result sits in an output register; samples of the next block are taken
//  while it waits, a second block end waits for the register to free
//  reset (async, active low) loads register defaults and clears all counters
//  cfg_i is always ready; writing start_gain also loads the running gain
// ----------------------------------------------------------------------------
`default_nettype none

module clip_driven_step_agc_top #(
  parameter int unsigned MaxBlock = cagc_pkg::MaxBlockDef
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  cagc_cfg_if.sink    cfg_i,
  cagc_in_if.sink     in_i,
  cagc_out_if.source  out_o
);
  import cagc_pkg::*;

  localparam int unsigned CntW = $clog2(MaxBlock + 1);
  localparam logic [CntW-1:0] BlkMax = CntW'(MaxBlock);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLIPMUL,
    S_EVAL,
    S_GAINMUL,
    S_CLAMP,
    S_PCTMUL,
    S_OUT
  } state_e;

  // configuration registers
  logic [ThrW-1:0]  clip_thr_q;
  logic [TimeW-1:0] step_dn_q;
  logic [TimeW-1:0] step_up_q;
  logic [DownW-1:0] down_ratio_q;
  logic [GainW-1:0] up_ratio_q;
  logic [GainW-1:0] floor_q;
  logic [GainW-1:0] ceil_q;

  // running state
  state_e           state_q;
  logic [CntW-1:0]  blk_cnt_q;
  logic [CntW-1:0]  clip_cnt_q;
  logic [TimeW-1:0] ovl_time_q;
  logic [TimeW-1:0] cln_time_q;
  logic [GainW-1:0] gain_q;
  logic             over_q;
  logic             step_q;

  // output register
  logic             out_vld_q;
  logic [GainW-1:0] out_gain_q;
  logic [PctW-1:0]  out_pct_q;
  logic             out_chg_q;
  logic             out_ovl_q;

  logic cfg_wr;
  logic in_acc;
  assign cfg_i.ready = 1'b1;
  assign cfg_wr      = cfg_i.valid;
  assign in_i.ready  = (state_q == S_IDLE);
  assign in_acc      = in_i.valid && (state_q == S_IDLE);

  // ---------------------------------------------------------------------------
  // per-sample clip test and block end detection
  // ---------------------------------------------------------------------------
  logic signed [SampleW:0] smp_x;
  logic signed [SampleW:0] thr_pos;
  logic signed [SampleW:0] thr_neg;
  logic                    is_clip;
  logic [CntW-1:0]         blk_inc;
  logic [CntW-1:0]         clip_inc;
  logic                    blk_end;

  assign smp_x    = {in_i.sample[SampleW-1], in_i.sample};
  assign thr_pos  = signed'({2'b00, clip_thr_q});
  assign thr_neg  = -thr_pos;
  assign is_clip  = (smp_x > thr_pos) || (smp_x < thr_neg);
  assign blk_inc  = blk_cnt_q + 1'b1;
  assign clip_inc = clip_cnt_q + CntW'(is_clip);
  // a full block closes even without the last mark
  assign blk_end  = in_i.last || (blk_inc >= BlkMax);

  // ---------------------------------------------------------------------------
  // shared multiplier and its operand select
  // ---------------------------------------------------------------------------
  logic [MulW-1:0]  mul_a;
  logic [MulW-1:0]  mul_b;
  logic [ProdW-1:0] prod;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_CLIPMUL: begin
        mul_a = MulW'(clip_cnt_q);
        mul_b = Hundred;
      end
      S_GAINMUL: begin
        mul_a = gain_q;
        mul_b = over_q ? {1'b0, down_ratio_q} : up_ratio_q;
      end
      // percent product is held while the result waits in S_OUT
      S_PCTMUL, S_OUT: begin
        mul_a = gain_q;
        mul_b = Hundred;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  cagc_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  // ---------------------------------------------------------------------------
  // block end evaluation
  // ---------------------------------------------------------------------------
  // clip > n/100 (floor) is the same as 100*clip > n
  logic                  blk_over;
  logic [TimeW:0]        ovl_sum;
  logic [TimeW:0]        cln_sum;
  logic [TimeW-1:0]      ovl_sat;
  logic [TimeW-1:0]      cln_sat;
  logic                  step_dn;
  logic                  step_up;
  logic [ProdW-FracW-1:0] prod_hi;
  logic [GainW-1:0]      dn_gain;
  logic [GainW-1:0]      up_gain;
  logic [PctW-1:0]       pct;

  assign blk_over = prod > ProdW'(blk_cnt_q);
  assign ovl_sum  = {1'b0, ovl_time_q} + (TimeW+1)'(blk_cnt_q);
  assign cln_sum  = {1'b0, cln_time_q} + (TimeW+1)'(blk_cnt_q);
  // times saturate at full scale
  assign ovl_sat  = ovl_sum[TimeW] ? TimeMax : ovl_sum[TimeW-1:0];
  assign cln_sat  = cln_sum[TimeW] ? TimeMax : cln_sum[TimeW-1:0];
  assign step_dn  = ovl_sat >= step_dn_q;
  assign step_up  = cln_sat >= step_up_q;

  // product back to Q1.16, then clamp toward floor or ceiling; percent saturates at 100
  assign prod_hi = prod[ProdW-1:FracW];
  assign dn_gain = (prod_hi < {1'b0, floor_q}) ? floor_q : prod_hi[GainW-1:0];
  assign up_gain = (prod_hi > {1'b0, ceil_q})  ? ceil_q  : prod_hi[GainW-1:0];
  assign pct     = (prod_hi > (ProdW-FracW)'(PctMax)) ? PctMax : prod_hi[PctW-1:0];

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clip_thr_q   <= ClipThrRst;
      step_dn_q    <= StepDnRst;
      step_up_q    <= StepUpRst;
      down_ratio_q <= DownRatRst;
      up_ratio_q   <= UpRatRst;
      floor_q      <= FloorRst;
      ceil_q       <= CeilRst;
    end else if (cfg_wr) begin
      case (cfg_idx_e'(cfg_i.index))
        CFG_CLIP_THR:   clip_thr_q   <= cfg_i.data[ThrW-1:0];
        CFG_STEP_DN:    step_dn_q    <= cfg_i.data[TimeW-1:0];
        CFG_STEP_UP:    step_up_q    <= cfg_i.data[TimeW-1:0];
        CFG_DOWN_RATIO: down_ratio_q <= cfg_i.data[DownW-1:0];
        CFG_UP_RATIO:   up_ratio_q   <= cfg_i.data[GainW-1:0];
        CFG_GAIN_FLOOR: floor_q      <= cfg_i.data[GainW-1:0];
        CFG_GAIN_CEIL:  ceil_q       <= cfg_i.data[GainW-1:0];
        // start gain only loads the running gain in the sequencer
        CFG_START_GAIN: ;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // sequencer, counters, gain and output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      blk_cnt_q  <= '0;
      clip_cnt_q <= '0;
      ovl_time_q <= '0;
      cln_time_q <= '0;
      gain_q     <= StartGnRst;
      over_q     <= 1'b0;
      step_q     <= 1'b0;
      out_vld_q  <= 1'b0;
      out_gain_q <= '0;
      out_pct_q  <= '0;
      out_chg_q  <= 1'b0;
      out_ovl_q  <= 1'b0;
    end else begin
      // result taken downstream; S_OUT handles the register itself
      if (out_o.ready && (state_q != S_OUT)) begin
        out_vld_q <= 1'b0;
      end

      // start gain write loads the running gain
      if (cfg_wr && (cfg_idx_e'(cfg_i.index) == CFG_START_GAIN)) begin
        gain_q <= cfg_i.data[GainW-1:0];
      end

      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            blk_cnt_q  <= blk_inc;
            clip_cnt_q <= clip_inc;
            if (blk_end) begin
              state_q <= S_CLIPMUL;
            end
          end
        end
        S_CLIPMUL: begin
          state_q <= S_EVAL;
        end
        S_EVAL: begin
          over_q <= blk_over;
          if (blk_over) begin
            cln_time_q <= '0;
            ovl_time_q <= step_dn ? '0 : ovl_sat;
            step_q     <= step_dn;
            state_q    <= step_dn ? S_GAINMUL : S_PCTMUL;
          end else begin
            ovl_time_q <= '0;
            cln_time_q <= step_up ? '0 : cln_sat;
            step_q     <= step_up;
            state_q    <= step_up ? S_GAINMUL : S_PCTMUL;
          end
        end
        S_GAINMUL: begin
          state_q <= S_CLAMP;
        end
        S_CLAMP: begin
          gain_q  <= over_q ? dn_gain : up_gain;
          state_q <= S_PCTMUL;
        end
        S_PCTMUL: begin
          state_q <= S_OUT;
        end
        S_OUT: begin
          // wait for the output register to free up
          if (!out_vld_q || out_o.ready) begin
            out_vld_q  <= 1'b1;
            out_gain_q <= gain_q;
            out_pct_q  <= pct;
            out_chg_q  <= step_q;
            out_ovl_q  <= over_q;
            blk_cnt_q  <= '0;
            clip_cnt_q <= '0;
            state_q    <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_o.valid           = out_vld_q;
  assign out_o.gain            = out_gain_q;
  assign out_o.rf_gain_percent = out_pct_q;
  assign out_o.changed         = out_chg_q;
  assign out_o.overloaded      = out_ovl_q;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  // a down step never leaves the gain below the floor
  a_dn_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLAMP) && over_q |=> (gain_q >= floor_q))
    else $error("down step gain below floor");

  // an up step never leaves the gain above the ceiling
  a_up_ceil: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLAMP) && !over_q |=> (gain_q <= ceil_q))
    else $error("up step gain above ceiling");

  // overload and clean time are never both running
  a_one_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovl_time_q == '0) || (cln_time_q == '0))
    else $error("overload and clean time both nonzero");

  // block counter closes the block at the maximum length
  a_blk_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    blk_cnt_q <= BlkMax)
    else $error("block counter past maximum");

  // a pending result always carries a saturated percent
  a_pct: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (out_pct_q <= PctMax))
    else $error("rf gain percent above limit");

endmodule

`default_nettype wire

// ----- rtl/core/cagc_mul.sv -----
// ----------------------------------------------------------------------------
// cagc_mul
// shared unsigned multiplier with registered product
// ----------------------------------------------------------------------------
`default_nettype none

module cagc_mul (
  input  wire logic                         clk_i,
  input  wire logic [cagc_pkg::MulW-1:0]    a_i,
  input  wire logic [cagc_pkg::MulW-1:0]    b_i,
  output logic      [cagc_pkg::ProdW-1:0]   prod_o
);
  import cagc_pkg::*;

  logic [ProdW-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= ProdW'(a_i) * ProdW'(b_i);
  end

  assign prod_o = prod_q;

endmodule

`default_nettype wire
